/* rtl/core/generational_handle_slot_allocator_defines.svh */
// assertion helpers shared by the allocator rtl
`ifndef GENERATIONAL_HANDLE_SLOT_ALLOCATOR_DEFINES_SVH
`define GENERATIONAL_HANDLE_SLOT_ALLOCATOR_DEFINES_SVH

// property that must hold at every clock edge out of reset
`define GHSA_ASSERT(name, clk, rst_n, prop) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("%m: check failed");

// condition in one cycle implies a condition in the next
`define GHSA_ASSERT_NEXT(name, clk, rst_n, pre, post) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error("%m: check failed");

`endif

/* rtl/core/ghsa_pkg.sv */
package ghsa_pkg;

  // default sizing of the slot table
  localparam int unsigned MaxSlotsDef  = 16;
  localparam int unsigned MaxExtentDef = 4096;
  localparam int unsigned GenBitsDef   = 16;

  // fixed field widths
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 5;
  localparam int unsigned CapW     = 5;
  localparam int unsigned CountW   = 5;
  localparam int unsigned TallyW   = 16;
  localparam int unsigned HSlotW   = 8;
  localparam int unsigned HGenW    = 16;
  localparam int unsigned ExtW     = 16;
  localparam int unsigned StatusW  = 3;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic [1:0] {
    OP_CREATE  = 2'd0,
    OP_DESTROY = 2'd1,
    OP_QUERY   = 2'd2
  } op_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK         = 3'd0,
    ST_NOT_READY  = 3'd1,
    ST_BAD_FORMAT = 3'd2,
    ST_BAD_SIZE   = 3'd3,
    ST_NO_SLOT    = 3'd4,
    ST_BAD_HANDLE = 3'd5
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_DEVICE_READY  = 1'b0,
    CFG_SLOT_CAPACITY = 1'b1
  } cfg_idx_e;

  typedef struct packed {
    logic [1:0]        opcode;
    logic              format_is_rgba8;
    logic [ExtW-1:0]   target_width;
    logic [ExtW-1:0]   target_height;
    logic [HSlotW-1:0] handle_slot;
    logic [HGenW-1:0]  handle_generation;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HSlotW-1:0]  out_slot;
    logic [HGenW-1:0]   out_generation;
    logic [CountW-1:0]  active_count;
    logic [TallyW-1:0]  failed_count;
  } rsp_t;

  // write controls toward the slot table
  typedef struct packed {
    logic gen_we;
    logic act_we;
    logic act_val;
  } tbl_cmd_t;

  // index width for a table of n entries
  function automatic int unsigned idx_w(int unsigned n);
    return (n > 1) ? $clog2(n) : 1;
  endfunction

endpackage

/* rtl/core/ghsa_gen_unit.sv */
module ghsa_gen_unit #(
  parameter int unsigned GEN_BITS = ghsa_pkg::GenBitsDef
) (
  input  logic                       create_i,
  input  logic [GEN_BITS-1:0]        stored_i,
  input  logic [ghsa_pkg::HGenW-1:0] handle_gen_i,
  output logic                       match_o,
  output logic [GEN_BITS-1:0]        next_o
);
  import ghsa_pkg::*;

  localparam int unsigned CmpW = (GEN_BITS > HGenW) ? GEN_BITS : HGenW;

  logic [CmpW-1:0] operand;

  // one comparator: zero test on create, handle match otherwise
  assign operand = create_i ? '0 : CmpW'(handle_gen_i);
  assign match_o = (CmpW'(stored_i) == operand);

  // create lifts generation 0 to 1, destroy steps it with wrap
  always_comb begin
    if (create_i) begin
      next_o = match_o ? GEN_BITS'(1) : stored_i;
    end else begin
      next_o = stored_i + GEN_BITS'(1);
    end
  end

endmodule

/* rtl/core/ghsa_slot_table.sv */
module ghsa_slot_table #(
  parameter int unsigned MAX_SLOTS = ghsa_pkg::MaxSlotsDef,
  parameter int unsigned GEN_BITS  = ghsa_pkg::GenBitsDef
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic [ghsa_pkg::idx_w(MAX_SLOTS)-1:0]   addr_i,
  input  ghsa_pkg::tbl_cmd_t                      cmd_i,
  input  logic [GEN_BITS-1:0]                     wr_gen_i,
  output logic                                    act_o,
  output logic [GEN_BITS-1:0]                     gen_o
);
  import ghsa_pkg::*;

  logic [MAX_SLOTS-1:0] act_q;
  logic [MAX_SLOTS-1:0] gvld_q;
  logic                 rd_vld_q;
  logic [GEN_BITS-1:0]  mem_q [MAX_SLOTS];
  logic [GEN_BITS-1:0]  rd_q;

  // active marks and written marks, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q    <= '0;
      gvld_q   <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (cmd_i.act_we) begin
        act_q[addr_i] <= cmd_i.act_val;
      end
      if (cmd_i.gen_we) begin
        gvld_q[addr_i] <= 1'b1;
      end
      rd_vld_q <= gvld_q[addr_i];
    end
  end

  // generation memory, registered read
  always_ff @(posedge clk_i) begin
    if (cmd_i.gen_we) begin
      mem_q[addr_i] <= wr_gen_i;
    end
    rd_q <= mem_q[addr_i];
  end

  assign act_o = act_q[addr_i];
  // never written entry reads as generation 0
  assign gen_o = rd_vld_q ? rd_q : '0;

endmodule

/* rtl/core/generational_handle_slot_allocator.sv */
// Slot allocator for generational handles. A request is taken when start is
// high and busy is low; busy then stays high until the result is out. The
// result shows on rsp_o for exactly one cycle with result_valid_o high and
// cannot be held off, so the receiver must take it in that cycle. Query and
// destroy requests that reach the generation compare pass through the decode
// and compare states; requests turned away by the first checks (not ready,
// bad format or size, handle slot out of range, inactive or generation zero,
// unused opcode) end in decode. Create walks the active marks one slot per
// cycle from slot 0 over the shared table address and allocates the lowest
// free slot; a walk that reaches the usable capacity ends with no slot. The
// generation memory has one port with a registered read, so each compare or
// update uses the value read in the state before it. A new request may be
// accepted in the cycle the result is shown. Configuration writes take effect
// at once and should only be issued while busy is low.
`include "generational_handle_slot_allocator_defines.svh"

module generational_handle_slot_allocator #(
  parameter int unsigned MAX_SLOTS  = ghsa_pkg::MaxSlotsDef,
  parameter int unsigned MAX_EXTENT = ghsa_pkg::MaxExtentDef,
  parameter int unsigned GEN_BITS   = ghsa_pkg::GenBitsDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  logic                          cfg_we_i,
  input  logic [ghsa_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [ghsa_pkg::CfgDataW-1:0] cfg_data_i,
  input  ghsa_pkg::req_t                req_i,
  output logic                          result_valid_o,
  output ghsa_pkg::rsp_t                rsp_o
);
  import ghsa_pkg::*;

  localparam int unsigned SlotW = idx_w(MAX_SLOTS);
  localparam int unsigned ScanW = $clog2(MAX_SLOTS + 1);
  localparam int unsigned UseW  = (ScanW > CapW) ? ScanW : CapW;
  localparam int unsigned CmpW  = (UseW > HSlotW) ? UseW : HSlotW;
  localparam logic [ExtW-1:0] ExtMax = ExtW'(MAX_EXTENT);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_SCAN,
    S_ALLOC,
    S_COMPARE
  } state_e;

  state_e              state_q, state_d;
  req_t                req_q;
  rsp_t                rsp_q;
  logic                valid_q;
  logic                ready_q;
  logic [CapW-1:0]     cap_q;
  logic [ScanW-1:0]    scan_q, scan_d;
  logic [CountW-1:0]   live_q, live_d;
  logic [TallyW-1:0]   tally_q, tally_d;

  logic                done;
  logic                fail;
  status_e             status;
  logic [HSlotW-1:0]   oslot;
  logic [HGenW-1:0]    ogen;

  logic [UseW-1:0]     usable;
  logic                size_ok;
  logic                handle_pre;
  logic                scan_end;
  logic                is_destroy;
  logic                rsp_err;

  tbl_cmd_t            tbl_cmd;
  logic                act_rd;
  logic [GEN_BITS-1:0] gen_rd;
  logic                gen_match;
  logic [GEN_BITS-1:0] gen_next;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ready_q <= 1'b0;
      cap_q   <= CapReset;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_DEVICE_READY:  ready_q <= cfg_data_i[0];
        CFG_SLOT_CAPACITY: cap_q   <= cfg_data_i[CapW-1:0];
        default: ;
      endcase
    end
  end

  // capacity saturated to the table depth
  always_comb begin
    if (UseW'(cap_q) > UseW'(MAX_SLOTS)) begin
      usable = UseW'(MAX_SLOTS);
    end else begin
      usable = UseW'(cap_q);
    end
  end

  assign is_destroy = (req_q.opcode == OP_DESTROY);

  assign size_ok = (req_q.target_width != '0) && (req_q.target_height != '0) &&
                   (req_q.target_width <= ExtMax) && (req_q.target_height <= ExtMax);

  // handle checks that need no stored generation
  assign handle_pre = ready_q && (req_q.handle_generation != '0) &&
                      (CmpW'(req_q.handle_slot) < CmpW'(usable)) && act_rd;

  assign scan_end = (UseW'(scan_q) >= usable);

  // slot table and shared generation compare / step unit
  ghsa_slot_table #(
    .MAX_SLOTS(MAX_SLOTS),
    .GEN_BITS (GEN_BITS)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .addr_i  (scan_q[SlotW-1:0]),
    .cmd_i   (tbl_cmd),
    .wr_gen_i(gen_next),
    .act_o   (act_rd),
    .gen_o   (gen_rd)
  );

  ghsa_gen_unit #(
    .GEN_BITS(GEN_BITS)
  ) u_gen (
    .create_i    (state_q == S_ALLOC),
    .stored_i    (gen_rd),
    .handle_gen_i(req_q.handle_generation),
    .match_o     (gen_match),
    .next_o      (gen_next)
  );

  // table writes on allocate and on a matching destroy
  always_comb begin
    tbl_cmd = '0;
    if (state_q == S_ALLOC) begin
      tbl_cmd.gen_we  = 1'b1;
      tbl_cmd.act_we  = 1'b1;
      tbl_cmd.act_val = 1'b1;
    end else if (state_q == S_COMPARE && gen_match && is_destroy) begin
      tbl_cmd.gen_we  = 1'b1;
      tbl_cmd.act_we  = 1'b1;
      tbl_cmd.act_val = 1'b0;
    end
  end

  // sequencer next state and result
  always_comb begin
    state_d = state_q;
    scan_d  = scan_q;
    live_d  = live_q;
    done    = 1'b0;
    fail    = 1'b0;
    status  = ST_OK;
    oslot   = '0;
    ogen    = '0;
    case (state_q)
      S_IDLE: begin
        if (start) begin
          state_d = S_DECODE;
          scan_d  = (req_i.opcode == OP_CREATE) ? '0 : ScanW'(req_i.handle_slot);
        end
      end
      S_DECODE: begin
        case (req_q.opcode)
          OP_CREATE: begin
            if (!ready_q) begin
              done = 1'b1; fail = 1'b1; status = ST_NOT_READY;
            end else if (!req_q.format_is_rgba8) begin
              done = 1'b1; fail = 1'b1; status = ST_BAD_FORMAT;
            end else if (!size_ok) begin
              done = 1'b1; fail = 1'b1; status = ST_BAD_SIZE;
            end else begin
              state_d = S_SCAN;
            end
          end
          OP_DESTROY, OP_QUERY: begin
            if (handle_pre) begin
              state_d = S_COMPARE;
            end else begin
              done   = 1'b1;
              fail   = is_destroy;
              status = ST_BAD_HANDLE;
            end
          end
          default: begin
            done   = 1'b1;
            status = ST_BAD_HANDLE;
          end
        endcase
      end
      S_SCAN: begin
        if (scan_end) begin
          done = 1'b1; fail = 1'b1; status = ST_NO_SLOT;
        end else if (!act_rd) begin
          state_d = S_ALLOC;
        end else begin
          scan_d = scan_q + ScanW'(1);
        end
      end
      S_ALLOC: begin
        done   = 1'b1;
        live_d = live_q + CountW'(1);
        oslot  = HSlotW'(scan_q);
        ogen   = HGenW'(gen_next);
      end
      S_COMPARE: begin
        done = 1'b1;
        if (gen_match) begin
          if (is_destroy && live_q != '0) begin
            live_d = live_q - CountW'(1);
          end
        end else begin
          fail   = is_destroy;
          status = ST_BAD_HANDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
    if (done) begin
      state_d = S_IDLE;
    end
  end

  assign tally_d = tally_q + TallyW'(fail);

  // state, counters and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      req_q   <= '0;
      scan_q  <= '0;
      live_q  <= '0;
      tally_q <= '0;
      valid_q <= 1'b0;
      rsp_q   <= '0;
    end else begin
      state_q <= state_d;
      scan_q  <= scan_d;
      live_q  <= live_d;
      tally_q <= tally_d;
      valid_q <= done;
      if (state_q == S_IDLE && start) begin
        req_q <= req_i;
      end
      if (done) begin
        rsp_q.status         <= status;
        rsp_q.out_slot       <= oslot;
        rsp_q.out_generation <= ogen;
        rsp_q.active_count   <= live_d;
        rsp_q.failed_count   <= tally_d;
      end
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = valid_q;
  assign rsp_o          = rsp_q;

  // failed result on the ports
  assign rsp_err = result_valid_o && (rsp_o.status != ST_OK);

  // checks
  `GHSA_ASSERT(a_result_when_idle, clk_i, rst_ni, result_valid_o |-> !busy)
  `GHSA_ASSERT_NEXT(a_accept_goes_busy, clk_i, rst_ni, start && !busy, busy)
  `GHSA_ASSERT(a_fail_has_no_gen, clk_i, rst_ni, rsp_err |-> rsp_o.out_generation == '0)
  `GHSA_ASSERT_NEXT(a_idle_tally_held, clk_i, rst_ni, state_q == S_IDLE, $stable(tally_q))

endmodule

/* tb/tb_generational_handle_slot_allocator.sv */
`timescale 1ns / 1ps

module tb_generational_handle_slot_allocator;
  import ghsa_pkg::*;

  localparam int unsigned MaxSlots    = MaxSlotsDef;
  localparam int unsigned MaxExtent   = MaxExtentDef;
  localparam logic [1:0]  OpUnused    = 2'd3;
  localparam int unsigned CycleLimit  = 3_000_000;
  localparam int unsigned DrainCycles = 40;
  localparam int unsigned ReuseRounds = 16;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                start;
  logic                busy;
  logic                cfg_we_i;
  logic [CfgIdxW-1:0]  cfg_idx_i;
  logic [CfgDataW-1:0] cfg_data_i;
  req_t                req_i;
  logic                result_valid_o;
  rsp_t                rsp_o;

  // predictor copy of the slot table and its settings
  logic              slot_live [MaxSlots];
  logic [HGenW-1:0]  slot_gen  [MaxSlots];
  logic [CountW-1:0] live_cnt;
  logic [TallyW-1:0] fail_tally;
  logic              dev_ready;
  logic [CapW-1:0]   slot_cap;

  rsp_t        rsp_due_q [$];
  rsp_t        want_rsp;
  int unsigned mismatch_cnt = 0;
  int unsigned req_cnt      = 0;
  int unsigned rsp_cnt      = 0;
  int unsigned reuse_cnt    = 0;
  int unsigned burst_left   = 0;
  int unsigned cycle_cnt    = 0;

  generational_handle_slot_allocator u_top (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .req_i          (req_i),
    .result_valid_o (result_valid_o),
    .rsp_o          (rsp_o)
  );

  always #10 clk_i = ~clk_i;

  // run limit
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // slots reachable under the current capacity
  function automatic int unsigned usable_slots();
    return (slot_cap > MaxSlots) ? MaxSlots : int'(slot_cap);
  endfunction

  function automatic logic handle_live(logic [HSlotW-1:0] hs, logic [HGenW-1:0] hg);
    if (!dev_ready || hg == '0 || hs >= usable_slots()) return 1'b0;
    return slot_live[hs] && (slot_gen[hs] == hg);
  endfunction

  // next response of the slot table, updating the predictor state
  function automatic rsp_t slot_table_step(req_t r);
    rsp_t        o;
    int unsigned n;
    int          free_idx;
    o = '0;
    n = usable_slots();
    free_idx = -1;
    case (r.opcode)
      OP_CREATE: begin
        if (!dev_ready) begin
          o.status = ST_NOT_READY;
        end else if (!r.format_is_rgba8) begin
          o.status = ST_BAD_FORMAT;
        end else if (r.target_width == '0 || r.target_height == '0 ||
                     r.target_width > MaxExtent || r.target_height > MaxExtent) begin
          o.status = ST_BAD_SIZE;
        end else begin
          for (int i = 0; i < n; i++) begin
            if (!slot_live[i] && free_idx < 0) free_idx = i;
          end
          if (free_idx < 0) begin
            o.status = ST_NO_SLOT;
          end else begin
            // a generation of zero, never used or wrapped, restarts at one
            if (slot_gen[free_idx] == '0) slot_gen[free_idx] = 1;
            slot_live[free_idx] = 1'b1;
            live_cnt++;
            o.status         = ST_OK;
            o.out_slot       = HSlotW'(free_idx);
            o.out_generation = slot_gen[free_idx];
          end
        end
        if (o.status != ST_OK) fail_tally++;
      end
      OP_DESTROY: begin
        if (!handle_live(r.handle_slot, r.handle_generation)) begin
          o.status = ST_BAD_HANDLE;
          fail_tally++;
        end else begin
          slot_live[r.handle_slot] = 1'b0;
          slot_gen[r.handle_slot]++;
          if (live_cnt != '0) live_cnt--;
        end
      end
      OP_QUERY: begin
        o.status = handle_live(r.handle_slot, r.handle_generation) ? ST_OK : ST_BAD_HANDLE;
      end
      default: begin
        o.status = ST_BAD_HANDLE;
      end
    endcase
    o.active_count = live_cnt;
    o.failed_count = fail_tally;
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mismatch_cnt++;
    end
  endfunction

  // result checker
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      if (rsp_due_q.size() == 0) begin
        $error("result with no request outstanding");
        mismatch_cnt++;
      end else begin
        want_rsp = rsp_due_q.pop_front();
        check_field("status", want_rsp.status, rsp_o.status);
        check_field("out_slot", want_rsp.out_slot, rsp_o.out_slot);
        check_field("out_generation", want_rsp.out_generation, rsp_o.out_generation);
        check_field("active_count", want_rsp.active_count, rsp_o.active_count);
        check_field("failed_count", want_rsp.failed_count, rsp_o.failed_count);
        rsp_cnt++;
      end
    end
  end

  // request builders, unused fields get random content
  function automatic req_t create_req(logic fmt, logic [ExtW-1:0] w, logic [ExtW-1:0] h);
    req_t r;
    r.opcode            = OP_CREATE;
    r.format_is_rgba8   = fmt;
    r.target_width      = w;
    r.target_height     = h;
    r.handle_slot       = $urandom_range(0, 255);
    r.handle_generation = $urandom_range(0, 65535);
    return r;
  endfunction

  function automatic req_t handle_req(logic [1:0] op, logic [HSlotW-1:0] hs,
                                      logic [HGenW-1:0] hg);
    req_t r;
    r.opcode            = op;
    r.format_is_rgba8   = $urandom_range(0, 1);
    r.target_width      = $urandom_range(0, 65535);
    r.target_height     = $urandom_range(0, 65535);
    r.handle_slot       = hs;
    r.handle_generation = hg;
    return r;
  endfunction

  function automatic logic [ExtW-1:0] good_extent();
    case ($urandom_range(0, 5))
      0: return 1;
      1: return MaxExtent;
      default: return $urandom_range(1, MaxExtent);
    endcase
  endfunction

  function automatic logic [ExtW-1:0] any_extent();
    case ($urandom_range(0, 4))
      0: return 0;
      1: return ExtW'(MaxExtent + 1);
      2: return 16'hFFFF;
      default: return $urandom_range(0, 65535);
    endcase
  endfunction

  function automatic int pick_live_slot();
    int cand [$];
    for (int i = 0; i < usable_slots(); i++) begin
      if (slot_live[i]) cand.push_back(i);
    end
    if (cand.size() == 0) return -1;
    return cand[$urandom_range(0, cand.size() - 1)];
  endfunction

  // mostly well-formed traffic on live handles, some broken requests and noise
  function automatic req_t random_req();
    req_t        r;
    int          s;
    int unsigned pick;
    pick = $urandom_range(0, 99);
    s = pick_live_slot();
    if (pick < 40 || (pick < 82 && s < 0)) begin
      r = create_req(1'b1, good_extent(), good_extent());
    end else if (pick < 58) begin
      r = handle_req(OP_DESTROY, HSlotW'(s), slot_gen[s]);
    end else if (pick < 72) begin
      r = handle_req(OP_QUERY, HSlotW'(s), slot_gen[s]);
    end else if (pick < 82) begin
      // live slot with a stale or corrupted generation
      r = handle_req($urandom_range(0, 1) ? OP_DESTROY : OP_QUERY, HSlotW'(s),
                     $urandom_range(0, 1) ? slot_gen[s] - 1 :
                                            slot_gen[s] ^ (16'd1 << $urandom_range(0, 15)));
    end else if (pick < 90) begin
      r = create_req($urandom_range(0, 1), any_extent(), any_extent());
    end else begin
      r = handle_req($urandom_range(0, 3), $urandom_range(0, 255), $urandom_range(0, 65535));
    end
    return r;
  endfunction

  // sender gap, with occasional back-to-back bursts
  function automatic int unsigned draw_gap();
    if (burst_left > 0) begin
      burst_left--;
      return 0;
    end
    if ($urandom_range(0, 15) == 0) burst_left = $urandom_range(5, 20);
    return $urandom_range(0, 19);
  endfunction

  // issue one request and wait for it to be taken
  task automatic send_request(req_t r, int unsigned gap);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    req_i <= r;
    do @(posedge clk_i); while (busy !== 1'b0);
    rsp_due_q.push_back(slot_table_step(r));
    req_cnt++;
  endtask

  // hold off until every outstanding result is back and the block is idle
  task automatic quiesce();
    start <= 1'b0;
    do @(posedge clk_i); while (rsp_due_q.size() != 0 || busy !== 1'b0);
  endtask

  // write both registers while idle; upper ready bits are don't-care
  task automatic set_config(logic ready, logic [CapW-1:0] cap);
    quiesce();
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_DEVICE_READY;
    cfg_data_i <= CfgDataW'({$urandom(), ready});
    @(posedge clk_i);
    cfg_idx_i  <= CFG_SLOT_CAPACITY;
    cfg_data_i <= cap;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
    dev_ready = ready;
    slot_cap  = cap;
  endtask

  // everything fails before the device is marked ready
  task automatic test_not_ready();
    send_request(create_req(1'b1, 16'd64, 16'd64), draw_gap());
    send_request(handle_req(OP_DESTROY, 8'd0, 16'd1), draw_gap());
    send_request(handle_req(OP_QUERY, 8'd0, 16'd1), draw_gap());
    send_request(handle_req(OpUnused, 8'd0, 16'd1), draw_gap());
  endtask

  // create argument checks and their order, extent limits
  task automatic test_create_checks();
    set_config(1'b1, CapReset);
    send_request(create_req(1'b0, 16'd0, 16'd0), draw_gap());
    send_request(create_req(1'b1, 16'd0, 16'd100), draw_gap());
    send_request(create_req(1'b1, 16'd100, 16'd0), draw_gap());
    send_request(create_req(1'b1, ExtW'(MaxExtent + 1), 16'd1), draw_gap());
    send_request(create_req(1'b1, 16'd1, 16'hFFFF), draw_gap());
    send_request(create_req(1'b1, ExtW'(MaxExtent), ExtW'(MaxExtent)), draw_gap());
    send_request(create_req(1'b1, 16'd1, 16'd1), draw_gap());
  endtask

  // handle validity, stale handles, slot reuse with a new generation
  task automatic test_handles();
    send_request(handle_req(OP_QUERY, 8'd0, slot_gen[0]), draw_gap());
    send_request(handle_req(OP_QUERY, 8'd0, 16'd0), draw_gap());
    send_request(handle_req(OP_QUERY, 8'd255, slot_gen[0]), draw_gap());
    send_request(handle_req(OP_DESTROY, 8'd0, slot_gen[0]), draw_gap());
    send_request(handle_req(OP_DESTROY, 8'd0, slot_gen[0] - 1), draw_gap());
    send_request(handle_req(OP_QUERY, 8'd0, slot_gen[0] - 1), draw_gap());
    send_request(handle_req(OpUnused, 8'd1, slot_gen[1]), draw_gap());
    send_request(create_req(1'b1, 16'd8, 16'd8), draw_gap());
    send_request(handle_req(OP_QUERY, 8'd1, slot_gen[1] + 1), draw_gap());
  endtask

  // zero, small, saturating and shrunk capacity
  task automatic test_capacity();
    set_config(1'b1, 5'd0);
    send_request(create_req(1'b1, 16'd2, 16'd2), draw_gap());
    send_request(handle_req(OP_QUERY, 8'd0, slot_gen[0]), draw_gap());
    set_config(1'b1, 5'd2);
    send_request(create_req(1'b1, 16'd3, 16'd3), draw_gap());
    send_request(handle_req(OP_DESTROY, 8'd1, slot_gen[1]), draw_gap());
    send_request(create_req(1'b1, 16'd4, 16'd4), draw_gap());
    set_config(1'b1, 5'd31);
    send_request(create_req(1'b1, 16'd5, 16'd5), draw_gap());
    send_request(handle_req(OP_QUERY, HSlotW'(MaxSlots), 16'd1), draw_gap());
    // slot 1 stays live but out of reach
    set_config(1'b1, 5'd1);
    send_request(handle_req(OP_QUERY, 8'd1, slot_gen[1]), draw_gap());
    send_request(handle_req(OP_DESTROY, 8'd1, slot_gen[1]), draw_gap());
    set_config(1'b1, CapReset);
    send_request(handle_req(OP_QUERY, 8'd1, slot_gen[1]), draw_gap());
  endtask

  // cycle slot 0 back to back, each pass moves its generation on
  task automatic test_slot_reuse();
    set_config(1'b1, 5'd1);
    if (slot_live[0]) send_request(handle_req(OP_DESTROY, 8'd0, slot_gen[0]), 0);
    repeat (ReuseRounds) begin
      send_request(create_req(1'b1, good_extent(), good_extent()), 0);
      send_request(handle_req(OP_DESTROY, 8'd0, slot_gen[0]), 0);
      reuse_cnt++;
    end
    send_request(create_req(1'b1, 16'd1, 16'd1), 0);
    send_request(handle_req(OP_QUERY, 8'd0, 16'hFFFF), 0);
    send_request(handle_req(OP_DESTROY, 8'd0, slot_gen[0]), 0);
  endtask

  task automatic run_phase(logic ready, logic [CapW-1:0] cap, int unsigned count);
    set_config(ready, cap);
    repeat (count) begin
      if ($urandom_range(0, 39) == 0) quiesce();
      send_request(random_req(), draw_gap());
    end
  endtask

  // random traffic across several register settings
  task automatic test_random();
    run_phase(1'b1, 5'd16, 110);
    run_phase(1'b1, 5'd3, 70);
    run_phase(1'b1, 5'd31, 70);
    run_phase(1'b0, 5'd9, 40);
    run_phase(1'b1, 5'd1, 50);
    run_phase(1'b1, 5'd0, 30);
    run_phase(1'b1, 5'd12, 130);
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    cfg_we_i   = 1'b0;
    cfg_idx_i  = CFG_DEVICE_READY;
    cfg_data_i = '0;
    req_i      = '0;
    for (int i = 0; i < MaxSlots; i++) begin
      slot_live[i] = 1'b0;
      slot_gen[i]  = '0;
    end
    live_cnt   = '0;
    fail_tally = '0;
    dev_ready  = 1'b0;
    slot_cap   = CapReset;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_not_ready();
    test_create_checks();
    test_handles();
    test_capacity();
    test_slot_reuse();
    test_random();

    quiesce();
    repeat (DrainCycles) @(posedge clk_i);

    $display("covered %0d requests, %0d results checked, %0d mismatches",
             req_cnt, rsp_cnt, mismatch_cnt);
    $display("slot 0 went through %0d back-to-back create/destroy pairs", reuse_cnt);
    if (mismatch_cnt == 0 && rsp_due_q.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

/* files.f */
+incdir+rtl/core
rtl/core/ghsa_pkg.sv
rtl/core/ghsa_gen_unit.sv
rtl/core/ghsa_slot_table.sv
rtl/core/generational_handle_slot_allocator.sv
tb/tb_generational_handle_slot_allocator.sv
